@@ sv/permutation_384_three_limb_macros.svh @@
// assertion macros shared by the permutation rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef PERMUTATION_384_THREE_LIMB_MACROS_SVH
`define PERMUTATION_384_THREE_LIMB_MACROS_SVH

// same-cycle implication, checked out of reset
`define P384_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define P384_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/perm3l_pkg.sv @@
// types, constants and the round function of the 384-bit three-limb permutation
// no dependencies
package perm3l_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned NumWords  = 6;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned RoundW    = 5;
  localparam int unsigned LimbW     = 128;
  localparam int unsigned StateW    = WordW * NumWords;
  localparam int unsigned ConstBits = 32;
  localparam int unsigned RcLen     = 32;

  localparam logic [RoundW-1:0] RoundsReset = RoundW'(16);
  localparam logic [IdxW-1:0]   LastIdx     = IdxW'(NumWords - 1);

  // round constant pattern, entry 0 leftmost
  localparam logic [0:RcLen-1] RcSeq = 32'b1111_1001_1010_0100_0010_1011_1011_0001;

  localparam int unsigned RotA1 = 110;
  localparam int unsigned RotA2 = 87;
  localparam int unsigned RotC1 = 118;
  localparam int unsigned RotC2 = 88;
  localparam int unsigned RcPos = 96;

  typedef enum logic [1:0] {
    StIdle,
    StFetch,
    StRound,
    StDrain
  } perm3l_state_e;

  typedef struct packed {
    logic [WordW-1:0] data_word;
    logic             last_word;
  } perm3l_in_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic [IdxW-1:0]  word_index;
    logic             last_result;
  } perm3l_out_t;

  // bit j of the result is bit (j+k) mod 128 of x
  function automatic logic [LimbW-1:0] rotr(input logic [LimbW-1:0] x, input int unsigned k);
    return (x >> k) | (x << (LimbW - k));
  endfunction

  function automatic logic [RcLen-1:0] rc_vec(input logic [RoundW-1:0] r);
    logic [RcLen-1:0] base;
    logic [RcLen-1:0] mask;
    for (int i = 0; i < RcLen; i++) begin
      base[i] = RcSeq[i];
      mask[i] = (i < ConstBits);
    end
    return (base << r) & mask;
  endfunction

  function automatic logic [StateW-1:0] round_f(input logic [StateW-1:0] s,
                                                input logic [RoundW-1:0] r);
    logic [LimbW-1:0] a;
    logic [LimbW-1:0] b;
    logic [LimbW-1:0] c;
    a = s[0 +: LimbW];
    b = s[LimbW +: LimbW];
    c = s[2*LimbW +: LimbW];
    a = a ^ rotr(a, RotA1) ^ rotr(a, RotA2);
    c[RcPos +: RcLen] = c[RcPos +: RcLen] ^ rc_vec(r);
    c = c ^ (a & b);
    c = c ^ rotr(c, RotC1) ^ rotr(c, RotC2);
    b = b ^ a ^ c;
    // limbs move round: (a,b,c) becomes (c,a,b)
    return {b, a, c};
  endfunction

endpackage

@@ sv/perm3l_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module perm3l_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 6,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/permutation_384_three_limb.sv @@
// top level of the 384-bit three-limb permutation
// depends on perm3l_pkg, perm3l_ram and permutation_384_three_limb_macros.svh
//
//  channel | dir | payload       | request
//  --------+-----+---------------+-------------------------------------
//  in      | in  | perm3l_in_t   | one state word, last word starts run
//  out     | out | perm3l_out_t  | one permuted word, six per run
//  cfg     | in  | 5-bit rounds  | round count, taken only while idle
//
// words load while idle, one per accepted input; a last word is followed by
// reading the word ram into the working register, round_count rounds (one
// round per cycle) and the drain of six words, which output stalls can hold.
// the fetch moves one ram word per cycle into the working register.
// reset clears control, the round count to 16 and the ram valid bits;
// a word never written reads as zero. no request is taken while running.
`include "permutation_384_three_limb_macros.svh"

module permutation_384_three_limb
  import perm3l_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  perm3l_in_t          in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output perm3l_out_t         out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RoundW-1:0]   cfg_data_i
);

  localparam logic [IdxW-1:0] FetchEnd = IdxW'(NumWords);

  perm3l_state_e state_q, state_d;

  logic [RoundW-1:0]             cfg_q;
  logic [IdxW-1:0]               load_q, load_d;
  logic [IdxW-1:0]               fetch_q, fetch_d;
  logic [RoundW-1:0]             rnd_q, rnd_d;
  logic [IdxW-1:0]               drain_q, drain_d;
  logic [NumWords-1:0]           valid_q, valid_d;
  logic [NumWords-1:0][WordW-1:0] work_q, work_d;

  logic             in_acc;
  logic             out_acc;
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_rdata;
  logic [IdxW-1:0]  cap_idx;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign cap_idx = fetch_q - IdxW'(1);

  perm3l_ram #(
    .Width (WordW),
    .Depth (NumWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && in_data_i.last_word) state_d = StFetch;
      end
      StFetch: begin
        if (fetch_q == FetchEnd) state_d = (cfg_q == '0) ? StDrain : StRound;
      end
      StRound: begin
        if (rnd_q == cfg_q - RoundW'(1)) state_d = StDrain;
      end
      StDrain: begin
        if (out_acc && drain_q == LastIdx) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs, ram port and counters
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cfg_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = load_q;
    ram_wdata   = in_data_i.data_word;
    ram_raddr   = '0;
    load_d      = load_q;
    fetch_d     = fetch_q;
    rnd_d       = rnd_q;
    drain_d     = drain_q;
    valid_d     = valid_q;
    work_d      = work_q;
    unique case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cfg_ready_o = 1'b1;
        fetch_d     = '0;
        if (in_acc) begin
          ram_we           = 1'b1;
          valid_d[load_q]  = 1'b1;
          if (in_data_i.last_word) begin
            load_d = '0;
          end else if (load_q != LastIdx) begin
            load_d = load_q + IdxW'(1);
          end
        end
      end
      StFetch: begin
        rnd_d   = '0;
        drain_d = '0;
        if (fetch_q != FetchEnd) begin
          ram_raddr = fetch_q;
          fetch_d   = fetch_q + IdxW'(1);
        end
        // read data arrives in the cycle after its address
        if (fetch_q != '0) begin
          work_d[cap_idx] = valid_q[cap_idx] ? ram_rdata : '0;
        end
      end
      StRound: begin
        work_d = round_f(work_q, rnd_q);
        rnd_d  = rnd_q + RoundW'(1);
      end
      StDrain: begin
        out_valid_o = 1'b1;
        // write back as each word leaves
        ram_waddr   = drain_q;
        ram_wdata   = work_q[drain_q];
        if (out_acc) begin
          ram_we           = 1'b1;
          valid_d[drain_q] = 1'b1;
          drain_d          = (drain_q == LastIdx) ? '0 : drain_q + IdxW'(1);
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign out_data_o.result_word = work_q[drain_q];
  assign out_data_o.word_index  = drain_q;
  assign out_data_o.last_result = (drain_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cfg_q   <= RoundsReset;
      load_q  <= '0;
      fetch_q <= '0;
      rnd_q   <= '0;
      drain_q <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      load_q  <= load_d;
      fetch_q <= fetch_d;
      rnd_q   <= rnd_d;
      drain_q <= drain_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  `P384_ASSERT_IMP(a_no_overlap, out_valid_o, !in_ready_o, "input taken while draining")
  `P384_ASSERT_IMP(a_drain_range, state_q == StDrain, drain_q <= LastIdx, "drain index out of range")
  `P384_ASSERT_IMP(a_round_bound, state_q == StRound, rnd_q < cfg_q, "round counter overran")
  `P384_ASSERT_NXT(a_start_fetch, in_acc && in_data_i.last_word, state_q == StFetch && fetch_q == '0, "last word did not start fetch")
  `P384_ASSERT_NXT(a_back_idle, out_acc && out_data_o.last_result, in_ready_o && load_q == '0, "not idle after last result")

endmodule
